// File: sv/gsk_pkg.sv
`default_nettype none

package gsk_pkg;

  // field widths
  localparam int unsigned CarbonW   = 8;
  localparam int unsigned HydrogenW = 8;
  localparam int unsigned NameW     = 10;
  localparam int unsigned KeyW      = CarbonW + HydrogenW;

  // one stored record
  typedef struct packed {
    logic [CarbonW-1:0]   carbon;
    logic [HydrogenW-1:0] hydrogen;
    logic [NameW-1:0]     name_id;
  } rec_t;

  // controller -> datapath commands
  typedef struct packed {
    logic ins;      // insert the incoming word into the cell chain
    logic ovf_set;  // chain full, word dropped
    logic pop;      // move head cell into the output register, shift chain
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic full;      // every cell holds a record
    logic out_free;  // output register can take a word this cycle
    logic last;      // exactly one record left in the chain
  } sts_t;

endpackage

`default_nettype wire

// File: sv/gsk_ctrl.sv
`default_nettype none

module gsk_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          final_req_i,
  output logic               in_stall_o,
  input  gsk_pkg::sts_t      sts_i,
  output gsk_pkg::cmd_t      cmd_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StEmit = 1'b1;

  logic state_q, state_d;
  logic take;

  // input words are taken only while collecting
  assign in_stall_o = (state_q != StIdle);
  assign take       = in_valid_i && (state_q == StIdle);

  always_comb begin
    cmd_o.ins     = take && !sts_i.full;
    cmd_o.ovf_set = take && sts_i.full;
    cmd_o.pop     = (state_q == StEmit) && sts_i.out_free;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (take && final_req_i) state_d = StEmit;
      end
      StEmit: begin
        if (sts_i.out_free && sts_i.last) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/gsk_dp.sv
`default_nettype none

module gsk_dp #(
  parameter int unsigned MaxRecords = 64
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic [gsk_pkg::CarbonW-1:0]     carbon_i,
  input  wire logic [gsk_pkg::HydrogenW-1:0]   hydrogen_i,
  input  wire logic [gsk_pkg::NameW-1:0]       name_id_i,
  input  gsk_pkg::cmd_t                        cmd_i,
  output gsk_pkg::sts_t                        sts_o,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [gsk_pkg::CarbonW-1:0]          out_carbon_o,
  output logic [gsk_pkg::HydrogenW-1:0]        out_hydrogen_o,
  output logic [gsk_pkg::NameW-1:0]            out_name_id_o,
  output logic                                 group_start_o,
  output logic                                 overflowed_o,
  output logic                                 last_out_o
);

  localparam int unsigned CntW = $clog2(MaxRecords + 1);

  gsk_pkg::rec_t                 cell_q [MaxRecords];
  gsk_pkg::rec_t                 new_rec;
  logic [MaxRecords-1:0]         le;
  logic [CntW-1:0]               count_q;
  logic                          ovf_q;
  logic                          first_q;
  logic [gsk_pkg::KeyW-1:0]      prev_key_q;
  logic [gsk_pkg::KeyW-1:0]      new_key;
  logic [gsk_pkg::KeyW-1:0]      head_key;
  logic                          out_valid_q;
  gsk_pkg::rec_t                 out_rec_q;
  logic                          out_start_q;
  logic                          out_ovf_q;
  logic                          out_last_q;

  assign new_rec  = '{carbon: carbon_i, hydrogen: hydrogen_i, name_id: name_id_i};
  assign new_key  = {carbon_i, hydrogen_i};
  assign head_key = {cell_q[0].carbon, cell_q[0].hydrogen};

  // status
  assign sts_o.full     = (count_q == CntW'(MaxRecords));
  assign sts_o.last     = (count_q == CntW'(1));
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  // insertion cells: each compares its key with the new one
  for (genvar i = 0; i < MaxRecords; i++) begin : g_cell
    assign le[i] = (CntW'(i) < count_q) &&
                   ({cell_q[i].carbon, cell_q[i].hydrogen} <= new_key);

    if (i == 0) begin : g_head
      // head cell: takes the new word when it sorts first, feeds the output
      always_ff @(posedge clk_i) begin
        if (cmd_i.ins) begin
          if (!le[0]) cell_q[0] <= new_rec;
        end else if (cmd_i.pop) begin
          cell_q[0] <= cell_q[1];
        end
      end
    end else if (i == MaxRecords - 1) begin : g_tail
      // tail cell: nothing behind it to shift in on a pop
      always_ff @(posedge clk_i) begin
        if (cmd_i.ins) begin
          if (!le[i]) cell_q[i] <= le[i-1] ? new_rec : cell_q[i-1];
        end
      end
    end else begin : g_body
      always_ff @(posedge clk_i) begin
        if (cmd_i.ins) begin
          if (!le[i]) cell_q[i] <= le[i-1] ? new_rec : cell_q[i-1];
        end else if (cmd_i.pop) begin
          cell_q[i] <= cell_q[i+1];
        end
      end
    end
  end

  // record count, overflow and group tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      first_q <= 1'b1;
    end else begin
      if (cmd_i.ins) count_q <= count_q + CntW'(1);
      else if (cmd_i.pop) count_q <= count_q - CntW'(1);
      if (cmd_i.ovf_set) ovf_q <= 1'b1;
      else if (cmd_i.pop && sts_o.last) ovf_q <= 1'b0;
      if (cmd_i.pop) first_q <= sts_o.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pop) prev_key_q <= head_key;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.pop) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pop) begin
      out_rec_q   <= cell_q[0];
      out_start_q <= first_q || (head_key != prev_key_q);
      out_ovf_q   <= ovf_q;
      out_last_q  <= sts_o.last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_carbon_o   = out_rec_q.carbon;
  assign out_hydrogen_o = out_rec_q.hydrogen;
  assign out_name_id_o  = out_rec_q.name_id;
  assign group_start_o  = out_start_q;
  assign overflowed_o   = out_ovf_q;
  assign last_out_o     = out_last_q;

endmodule

`default_nettype wire

// File: sv/group_and_sort_by_key_pair.sv
// Channel | Direction | Handshake                | Word
// in      | input     | in_valid_i / in_stall_o  | carbon, hydrogen, name_id, final_req
// out     | output    | out_valid_o / out_stall_i| carbon, hydrogen, name_id, flags
//
// Collecting: one input word per cycle, placed by the insertion cell chain.
// On a word with final_req the block emits every stored record, one per cycle
// from the head of the chain, and holds in_stall_o high until the last word
// has moved into the output register. A stalled output holds the chain.
// Reset clears the record count, overflow flag and output valid; the cells
// need no clearing.
`default_nettype none

module group_and_sort_by_key_pair #(
  parameter int unsigned MaxRecords = 64
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [gsk_pkg::CarbonW-1:0]     carbon_i,
  input  wire logic [gsk_pkg::HydrogenW-1:0]   hydrogen_i,
  input  wire logic [gsk_pkg::NameW-1:0]       name_id_i,
  input  wire logic                            final_req_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [gsk_pkg::CarbonW-1:0]          out_carbon_o,
  output logic [gsk_pkg::HydrogenW-1:0]        out_hydrogen_o,
  output logic [gsk_pkg::NameW-1:0]            out_name_id_o,
  output logic                                 group_start_o,
  output logic                                 overflowed_o,
  output logic                                 last_out_o
);

  gsk_pkg::cmd_t cmd;
  gsk_pkg::sts_t sts;

  gsk_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .final_req_i (final_req_i),
    .in_stall_o  (in_stall_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gsk_dp #(
    .MaxRecords (MaxRecords)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .carbon_i       (carbon_i),
    .hydrogen_i     (hydrogen_i),
    .name_id_i      (name_id_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_carbon_o   (out_carbon_o),
    .out_hydrogen_o (out_hydrogen_o),
    .out_name_id_o  (out_name_id_o),
    .group_start_o  (group_start_o),
    .overflowed_o   (overflowed_o),
    .last_out_o     (last_out_o)
  );

endmodule

`default_nettype wire

// File: tb/tb_group_and_sort_by_key_pair.sv
`timescale 1ns / 1ps

module tb_group_and_sort_by_key_pair;

  localparam int unsigned MaxRecords = 64;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned TailCycles = 20;
  localparam int unsigned ItemGoal   = 330;

  // one input word as queued for the driver
  typedef struct {
    gsk_pkg::rec_t rec;
    logic          fin;
  } in_word_t;

  // one expected output word
  typedef struct {
    logic [gsk_pkg::CarbonW-1:0]   carbon;
    logic [gsk_pkg::HydrogenW-1:0] hydrogen;
    logic [gsk_pkg::NameW-1:0]     name_id;
    logic                          group_start;
    logic                          overflowed;
    logic                          last_out;
  } sorted_word_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic [gsk_pkg::CarbonW-1:0]   carbon_i = '0;
  logic [gsk_pkg::HydrogenW-1:0] hydrogen_i = '0;
  logic [gsk_pkg::NameW-1:0]     name_id_i = '0;
  logic                          final_req_i = 1'b0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [gsk_pkg::CarbonW-1:0]   out_carbon_o;
  logic [gsk_pkg::HydrogenW-1:0] out_hydrogen_o;
  logic [gsk_pkg::NameW-1:0]     out_name_id_o;
  logic                          group_start_o;
  logic                          overflowed_o;
  logic                          last_out_o;

  in_word_t      pending_words[$];
  gsk_pkg::rec_t held_records[$];
  sorted_word_t  sorted_words[$];
  logic          dropped_any = 1'b0;
  int            total_items = 0;
  int            n_sent = 0;
  int            n_accepted = 0;
  int            n_errors = 0;
  int            cycles = 0;

  group_and_sort_by_key_pair #(
    .MaxRecords(MaxRecords)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .carbon_i      (carbon_i),
    .hydrogen_i    (hydrogen_i),
    .name_id_i     (name_id_i),
    .final_req_i   (final_req_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_carbon_o  (out_carbon_o),
    .out_hydrogen_o(out_hydrogen_o),
    .out_name_id_o (out_name_id_o),
    .group_start_o (group_start_o),
    .overflowed_o  (overflowed_o),
    .last_out_o    (last_out_o)
  );

  always #1 clk_i = ~clk_i;

  // idle rates per phase: sender light / receiver heavy, then swapped, then none
  function automatic int sender_idle_pct();
    if (n_sent < total_items / 3) return 25;
    if (n_sent < 2 * total_items / 3) return 72;
    return 0;
  endfunction

  function automatic int receiver_stall_pct();
    if (n_sent < total_items / 3) return 72;
    if (n_sent < 2 * total_items / 3) return 25;
    return 0;
  endfunction

  // file one accepted word into the sorted store; on final, flush it as expectations
  task automatic file_record(input gsk_pkg::rec_t r, input logic fin);
    int           pos;
    sorted_word_t w;
    pos = 0;
    if (held_records.size() < MaxRecords) begin
      // goes after every record whose key is <= its own
      while (pos < held_records.size() &&
             {held_records[pos].carbon, held_records[pos].hydrogen} <=
             {r.carbon, r.hydrogen})
        pos++;
      held_records.insert(pos, r);
    end else begin
      dropped_any = 1'b1;
    end
    if (fin) begin
      foreach (held_records[k]) begin
        w.carbon      = held_records[k].carbon;
        w.hydrogen    = held_records[k].hydrogen;
        w.name_id     = held_records[k].name_id;
        w.group_start = (k == 0) ||
                        ({held_records[k].carbon, held_records[k].hydrogen} !=
                         {held_records[k-1].carbon, held_records[k-1].hydrogen});
        w.overflowed  = dropped_any;
        w.last_out    = (k == held_records.size() - 1);
        sorted_words.insert(sorted_words.size(), w);
      end
      held_records.delete();
      dropped_any = 1'b0;
    end
  endtask

  task automatic queue_word(input int c, input int h, input int n, input logic fin);
    in_word_t iw;
    iw.rec.carbon   = c[gsk_pkg::CarbonW-1:0];
    iw.rec.hydrogen = h[gsk_pkg::HydrogenW-1:0];
    iw.rec.name_id  = n[gsk_pkg::NameW-1:0];
    iw.fin          = fin;
    pending_words.insert(pending_words.size(), iw);
    total_items++;
  endtask

  // one set of records; narrow keys crowd records into shared groups
  task automatic queue_set(input int size);
    logic narrow;
    int   c0;
    int   h0;
    narrow = ($urandom_range(0, 2) != 0);
    c0     = $urandom_range(0, 255);
    h0     = $urandom_range(0, 255);
    for (int i = 0; i < size; i++) begin
      if (narrow)
        queue_word(c0 + $urandom_range(0, 2), h0 + $urandom_range(0, 2),
                   $urandom_range(0, 1023), i == size - 1);
      else
        queue_word($urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 1023), i == size - 1);
    end
  endtask

  // input driver: payload holds while stalled
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        file_record('{carbon: carbon_i, hydrogen: hydrogen_i, name_id: name_id_i},
                    final_req_i);
        n_accepted <= n_accepted + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_words.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
          in_valid_i  <= 1'b1;
          carbon_i    <= pending_words[0].rec.carbon;
          hydrogen_i  <= pending_words[0].rec.hydrogen;
          name_id_i   <= pending_words[0].rec.name_id;
          final_req_i <= pending_words[0].fin;
          void'(pending_words.pop_front());
          n_sent <= n_sent + 1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(input string field, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      n_errors++;
    end
  endfunction

  // output monitor and random receiver stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < receiver_stall_pct());
      if (out_valid_o && !out_stall_i) begin
        if (sorted_words.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual c=%0d h=%0d n=%0d",
                   $time, out_carbon_o, out_hydrogen_o, out_name_id_o);
          n_errors++;
        end else begin
          check_field("carbon", int'(sorted_words[0].carbon), int'(out_carbon_o));
          check_field("hydrogen", int'(sorted_words[0].hydrogen), int'(out_hydrogen_o));
          check_field("name_id", int'(sorted_words[0].name_id), int'(out_name_id_o));
          check_field("group_start", int'(sorted_words[0].group_start),
                      int'(group_start_o));
          check_field("overflowed", int'(sorted_words[0].overflowed), int'(overflowed_o));
          check_field("last_out", int'(sorted_words[0].last_out), int'(last_out_o));
          void'(sorted_words.pop_front());
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int n_sets;
    n_sets = 0;

    // directed: lone final record
    queue_word(0, 0, 0, 1'b1);
    // field extremes, several groups, repeated keys
    queue_word(255, 255, 1023, 1'b0);
    queue_word(0, 0, 1023, 1'b0);
    queue_word(255, 0, 0, 1'b0);
    queue_word(0, 255, 512, 1'b0);
    queue_word(255, 255, 0, 1'b0);
    queue_word(0, 0, 1, 1'b0);
    queue_word(128, 128, 341, 1'b0);
    queue_word(0, 0, 682, 1'b1);
    // one group only
    queue_word(7, 9, 10, 1'b0);
    queue_word(7, 9, 11, 1'b0);
    queue_word(7, 9, 12, 1'b1);
    // arrival in descending key order
    queue_word(3, 3, 1, 1'b0);
    queue_word(3, 2, 2, 1'b0);
    queue_word(2, 9, 3, 1'b0);
    queue_word(1, 0, 4, 1'b1);

    // random sets: mostly small, one exactly full, one that overflows
    // (the overflowing set also drops its final record)
    while (total_items < ItemGoal) begin
      if (n_sets == 3)
        queue_set(MaxRecords + 6);
      else if (n_sets == 20)
        queue_set(MaxRecords);
      else
        queue_set($urandom_range(1, 12));
      n_sets++;
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (n_accepted < total_items || sorted_words.size() > 0)
      @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (n_errors == 0 && sorted_words.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
